>>> hdl/bir_pkg.sv
// Shared constants, register codes and types of the bilinear image resampler.
package bir_pkg;

  // Frame store geometry and output range
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int OUT_DIM        = 512;
  localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);

  // Field widths
  localparam int DIM_W   = 9;   // src_width, src_height
  localparam int COORD_W = 8;   // origin, source column/row
  localparam int PIX_W   = 16;
  localparam int DST_W   = 9;
  localparam int SCALE_W = 24;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = SCALE_W + DST_W + 1;  // mapped position, 16 fraction bits
  localparam int INT_W   = POS_W - FRAC_W;
  localparam int LIN_W   = 2 * DIM_W + 1;        // linear address incl. neighbors
  localparam int WGT_W   = 2 * FRAC_W + 1;       // bilinear weight, up to 2^32
  localparam int PROD_W  = WGT_W + PIX_W - 1;    // weighted pixel, sum fits here
  localparam int RES_W   = 24;
  localparam int NB_N    = 4;                    // base, right, lower, diagonal

  localparam logic [FRAC_W:0]   FRAC_ONE   = (FRAC_W+1)'(1) << FRAC_W;
  localparam logic [FRAC_W-1:0] FRAC_MIN   = FRAC_W'(65);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (PROD_W - RES_W - 1);

  // Request kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_STEP = CFG_IDX_W'(4);

  localparam logic [DIM_W-1:0]   SRC_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST = DIM_W'(256);
  localparam logic [SCALE_W-1:0] SCALE_STEP_RST = SCALE_W'(65536);

  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [WGT_W-1:0]    wgt_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [STORE_AW-1:0] store_addr_t;

endpackage

>>> hdl/bir_if.sv
// Request, result and configuration channel interfaces of the resampler.
interface bir_in_if import bir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] src_col;
  logic [COORD_W-1:0] src_row;
  pix_t               src_value;
  logic [DST_W-1:0]   dst_col;
  logic [DST_W-1:0]   dst_row;

  modport source (output valid, action, src_col, src_row, src_value, dst_col, dst_row,
                  input ready);
  modport sink   (input valid, action, src_col, src_row, src_value, dst_col, dst_row,
                  output ready);
endinterface

interface bir_out_if import bir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] sample_value;
  logic             inside_res;

  modport source (output valid, sample_value, inside_res, input ready);
  modport sink   (input valid, sample_value, inside_res, output ready);
endinterface

interface bir_cfg_if import bir_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bilinear_image_resampler_unit.sv
// Bilinear image resampler: frame store, position mapping and interpolation pipeline.
//
// Channels: in_req carries requests. A write request (action 0) stores src_value at
// (src_col, src_row) of the frame store; a sample request (action 1) asks for output
// pixel (dst_col, dst_row) and yields exactly one result on out_res (sample_value in
// 16.8 fixed point, inside_res). Writes yield no result. cfg_wr writes the five
// registers (index 0..4); unknown indexes are dropped. Write config only while idle.
// Throughput: one request per cycle unless out_res stalls. The frame store is kept
// as two identical copies with two read ports each, so all four neighbor reads of a
// sample happen in the same cycle; writes update both copies.
// Pipeline: seven register stages (mapping multiply, bounds split, address multiply,
// weight multiply, store read, pixel multiply, sum); out_res.valid and the result
// come from the sum stage registers.
// Reset (rst_n low, synchronous) empties the pipeline and restores the register
// defaults; frame store contents are undefined until written, and no clearing pass runs.
// Stall: each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out; in_req.ready drops only when all seven stages hold requests and
// out_res.ready is low. Nothing is lost or repeated across a stall.
module bilinear_image_resampler_unit import bir_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bir_in_if.sink    in_req,
  bir_out_if.source out_res,
  bir_cfg_if.sink   cfg_wr
);

  // ---------------------------------------------------------------- configuration
  logic [DIM_W-1:0]   src_width_r;
  logic [DIM_W-1:0]   src_height_r;
  logic [COORD_W-1:0] origin_x_r;
  logic [COORD_W-1:0] origin_y_r;
  logic [SCALE_W-1:0] scale_step_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      scale_step_r <= SCALE_STEP_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_wr.data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_wr.data[DIM_W-1:0];
        REG_ORIGIN_X:   origin_x_r   <= cfg_wr.data[COORD_W-1:0];
        REG_ORIGIN_Y:   origin_y_r   <= cfg_wr.data[COORD_W-1:0];
        REG_SCALE_STEP: scale_step_r <= cfg_wr.data[SCALE_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // A stage may load when it is empty or its contents move on in the same cycle.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !v7_r || out_res.ready;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_req.ready = rdy1;

  // Payload registers of each stage
  logic                  s1_act_r, s1_bad_r;
  logic [COORD_W-1:0]    s1_col_r, s1_row_r;
  pix_t                  s1_val_r;
  logic [POS_W-1:0]      s1_x_r, s1_y_r;

  logic                  s2_act_r, s2_in_r;
  logic [DIM_W-1:0]      s2_col_r, s2_row_r;
  logic [FRAC_W-1:0]     s2_fx_r, s2_fy_r;
  pix_t                  s2_val_r;

  logic                  s3_act_r, s3_in_r;
  logic [LIN_W-1:0]      s3_base_r;
  logic [FRAC_W-1:0]     s3_fx_r, s3_fy_r;
  pix_t                  s3_val_r;

  logic                  s4_act_r, s4_in_r, s4_wr_ok_r;
  store_addr_t           s4_idx_r [NB_N];
  logic [NB_N-1:0]       s4_use_r;
  wgt_t                  s4_w_r [NB_N];
  pix_t                  s4_val_r;

  logic                  s5_in_r;
  pix_t                  s5_p_r [NB_N];
  logic [NB_N-1:0]       s5_use_r;
  wgt_t                  s5_w_r [NB_N];

  logic                  s6_in_r;
  prod_t                 s6_prod_r [NB_N];

  logic                  s7_in_r;
  logic [RES_W-1:0]      s7_val_r;

  // Valid bits travel with the data; writes leave the pipe after the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_req.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r && (s4_act_r == ACT_SAMPLE);
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  // ---------------------------------------------------------------- stage 1: map
  // Position = origin + scale_step * index, 16 fraction bits.
  logic [SCALE_W+DST_W-1:0] mul_x, mul_y;
  logic [POS_W-1:0]         pos_x, pos_y;
  logic                     dst_bad;

  always_comb begin
    mul_x   = (SCALE_W+DST_W)'(scale_step_r) * (SCALE_W+DST_W)'(in_req.dst_col);
    mul_y   = (SCALE_W+DST_W)'(scale_step_r) * (SCALE_W+DST_W)'(in_req.dst_row);
    pos_x   = POS_W'(mul_x) + POS_W'({origin_x_r, FRAC_W'(0)});
    pos_y   = POS_W'(mul_y) + POS_W'({origin_y_r, FRAC_W'(0)});
    dst_bad = (32'(in_req.dst_col) >= OUT_DIM) || (32'(in_req.dst_row) >= OUT_DIM);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_act_r <= in_req.action;
      s1_col_r <= in_req.src_col;
      s1_row_r <= in_req.src_row;
      s1_val_r <= in_req.src_value;
      s1_x_r   <= pos_x;
      s1_y_r   <= pos_y;
      s1_bad_r <= dst_bad;
    end
  end

  // ---------------------------------------------------------------- stage 2: split
  logic [INT_W-1:0] ix, iy;
  logic             in_bounds;

  always_comb begin
    ix        = s1_x_r[POS_W-1:FRAC_W];
    iy        = s1_y_r[POS_W-1:FRAC_W];
    in_bounds = !s1_bad_r && (ix < INT_W'(src_width_r)) && (iy < INT_W'(src_height_r));
  end

  // Writes reuse the coordinate registers for their column and row.
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_act_r <= s1_act_r;
      s2_in_r  <= in_bounds && (s1_act_r == ACT_SAMPLE);
      s2_col_r <= (s1_act_r == ACT_SAMPLE) ? ix[DIM_W-1:0] : DIM_W'(s1_col_r);
      s2_row_r <= (s1_act_r == ACT_SAMPLE) ? iy[DIM_W-1:0] : DIM_W'(s1_row_r);
      s2_fx_r  <= s1_x_r[FRAC_W-1:0];
      s2_fy_r  <= s1_y_r[FRAC_W-1:0];
      s2_val_r <= s1_val_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: address
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_act_r  <= s2_act_r;
      s3_in_r   <= s2_in_r;
      s3_base_r <= LIN_W'(s2_row_r) * LIN_W'(src_width_r) + LIN_W'(s2_col_r);
      s3_fx_r   <= s2_fx_r;
      s3_fy_r   <= s2_fy_r;
      s3_val_r  <= s2_val_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: weights
  logic [LIN_W-1:0]  nb_addr [NB_N];
  logic [NB_N-1:0]   nb_ok;
  logic [NB_N-1:0]   nb_use;
  logic              use_x, use_y;
  logic [FRAC_W:0]   gx, gy;
  wgt_t              nb_w [NB_N];

  always_comb begin
    nb_addr[0] = s3_base_r;
    nb_addr[1] = s3_base_r + LIN_W'(1);
    nb_addr[2] = s3_base_r + LIN_W'(src_width_r);
    nb_addr[3] = nb_addr[2] + LIN_W'(1);
    for (int k = 0; k < NB_N; k++) begin
      nb_ok[k] = 32'(nb_addr[k]) < STORE_DEPTH;
    end
    // Skip a neighbor whose fraction is negligible.
    use_x     = s3_fx_r > FRAC_MIN;
    use_y     = s3_fy_r > FRAC_MIN;
    nb_use[0] = s3_in_r && nb_ok[0];
    nb_use[1] = s3_in_r && use_x && nb_ok[1];
    nb_use[2] = s3_in_r && use_y && nb_ok[2];
    nb_use[3] = s3_in_r && use_x && use_y && nb_ok[3];
    gx        = FRAC_ONE - (FRAC_W+1)'(s3_fx_r);
    gy        = FRAC_ONE - (FRAC_W+1)'(s3_fy_r);
    nb_w[0]   = WGT_W'(gx) * WGT_W'(gy);
    nb_w[1]   = WGT_W'(s3_fx_r) * WGT_W'(gy);
    nb_w[2]   = WGT_W'(gx) * WGT_W'(s3_fy_r);
    nb_w[3]   = WGT_W'(s3_fx_r) * WGT_W'(s3_fy_r);
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_act_r   <= s3_act_r;
      s4_in_r    <= s3_in_r;
      s4_wr_ok_r <= nb_ok[0];
      s4_use_r   <= nb_use;
      s4_val_r   <= s3_val_r;
      for (int k = 0; k < NB_N; k++) begin
        s4_idx_r[k] <= STORE_AW'(nb_addr[k]);
        s4_w_r[k]   <= nb_w[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5: frame store
  // Two identical copies, two read ports each. Writes and reads both happen as a
  // request leaves stage 4, so store order follows request order.
  pix_t mem_a [STORE_DEPTH];
  pix_t mem_b [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (rdy5) begin
      if (v4_r && (s4_act_r == ACT_WRITE) && s4_wr_ok_r) begin
        mem_a[s4_idx_r[0]] <= s4_val_r;
        mem_b[s4_idx_r[0]] <= s4_val_r;
      end
      s5_p_r[0] <= mem_a[s4_idx_r[0]];
      s5_p_r[1] <= mem_a[s4_idx_r[1]];
      s5_p_r[2] <= mem_b[s4_idx_r[2]];
      s5_p_r[3] <= mem_b[s4_idx_r[3]];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_in_r  <= s4_in_r;
      s5_use_r <= s4_use_r;
      for (int k = 0; k < NB_N; k++) begin
        s5_w_r[k] <= s4_w_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 6: products
  // Mask skipped neighbors to zero before the multiply.
  pix_t pix_sel [NB_N];

  always_comb begin
    for (int k = 0; k < NB_N; k++) begin
      pix_sel[k] = s5_use_r[k] ? s5_p_r[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_in_r <= s5_in_r;
      for (int k = 0; k < NB_N; k++) begin
        s6_prod_r[k] <= PROD_W'(s5_w_r[k]) * PROD_W'(pix_sel[k]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 7: sum, output
  prod_t acc;

  always_comb begin
    acc = s6_prod_r[0] + s6_prod_r[1] + s6_prod_r[2] + s6_prod_r[3] + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_in_r  <= s6_in_r;
      s7_val_r <= s6_in_r ? acc[PROD_W-1:PROD_W-RES_W] : '0;
    end
  end

  assign out_res.valid        = v7_r;
  assign out_res.sample_value = s7_val_r;
  assign out_res.inside_res   = s7_in_r;

  // ---------------------------------------------------------------- assertions
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_res.valid && !out_res.inside_res) |-> (out_res.sample_value == '0))
    else $error("outside sample carries a nonzero value");

  a_diag_needs_sides: assert property (@(posedge clk) disable iff (!rst_n)
      (v5_r && s5_use_r[3]) |-> (s5_use_r[1] && s5_use_r[2]))
    else $error("diagonal neighbor used without right and lower");

  a_nb_needs_base: assert property (@(posedge clk) disable iff (!rst_n)
      (v5_r && (s5_use_r[1] || s5_use_r[2])) |-> s5_use_r[0])
    else $error("neighbor used without base pixel");

  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
      !in_req.ready |-> (v1_r && v7_r && !out_res.ready))
    else $error("input stalled while pipeline has room");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
      (v4_r && (s4_act_r == ACT_WRITE) && rdy5) |=> !v5_r)
    else $error("write request passed the frame store");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_res.valid)
    else $error("result valid after reset");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the bilinear image resampler: scoreboard, drivers, run plan.
module tb import bir_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 300_000;
  localparam int SETTLE_CYCLES   = 16;   // seven pipeline stages plus margin
  localparam int N_PHASES        = 8;
  localparam int PHASE_REQUESTS  = 120;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  localparam int DROP_BITS       = 24;   // 32 fraction bits of the sum down to 8
  localparam longint unsigned HALF_LSB = 64'd1 << (DROP_BITS - 1);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);

  typedef struct {
    logic               action;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    pix_t               src_value;
    logic [DST_W-1:0]   dst_col;
    logic [DST_W-1:0]   dst_row;
  } request_t;

  typedef struct {
    logic [RES_W-1:0] value;
    logic             in_img;
    logic [DST_W-1:0] dst_col;
    logic [DST_W-1:0] dst_row;
  } pixel_t;

  typedef struct {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [SCALE_W-1:0] scale;
  } setting_t;

  // Shadow of the frame store and registers; predicts one pixel per sample request.
  class pixel_scoreboard;
    pix_t               frame [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [SCALE_W-1:0] scale;
    longint unsigned    last_reads[$];
    pixel_t             pixels_due[$];
    int                 errors;

    function new();
      width  = SRC_WIDTH_RST;
      height = SRC_HEIGHT_RST;
      org_x  = '0;
      org_y  = '0;
      scale  = SCALE_STEP_RST;
      errors = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  width  = data[DIM_W-1:0];
        REG_SRC_HEIGHT: height = data[DIM_W-1:0];
        REG_ORIGIN_X:   org_x  = data[COORD_W-1:0];
        REG_ORIGIN_Y:   org_y  = data[COORD_W-1:0];
        REG_SCALE_STEP: scale  = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Past the end of the store a neighbor counts as zero.
    function longint unsigned fetch(input longint unsigned addr);
      if (addr >= STORE_DEPTH) return 0;
      last_reads.push_back(addr);
      return frame[addr];
    endfunction

    function pixel_t interpolate(input logic [DST_W-1:0] dcol, input logic [DST_W-1:0] drow);
      longint unsigned x, y, ix, iy, fx, fy, base, one, sum;
      pixel_t px;
      px.value   = '0;
      px.in_img  = 1'b0;
      px.dst_col = dcol;
      px.dst_row = drow;
      last_reads.delete();
      one = FRAC_ONE;
      x  = (64'(org_x) << FRAC_W) + 64'(scale) * 64'(dcol);
      y  = (64'(org_y) << FRAC_W) + 64'(scale) * 64'(drow);
      ix = x >> FRAC_W;
      iy = y >> FRAC_W;
      fx = x & (one - 1);
      fy = y & (one - 1);
      if (ix >= 64'(width) || iy >= 64'(height)) return px;
      base = iy * 64'(width) + ix;
      sum = (one - fx) * (one - fy) * fetch(base);
      // skip a neighbor whose fraction is negligible
      if (fx > FRAC_MIN) sum += fx * (one - fy) * fetch(base + 1);
      if (fy > FRAC_MIN) sum += (one - fx) * fy * fetch(base + 64'(width));
      if (fx > FRAC_MIN && fy > FRAC_MIN) sum += fx * fy * fetch(base + 64'(width) + 1);
      px.value  = RES_W'((sum + HALF_LSB) >> DROP_BITS);
      px.in_img = 1'b1;
      return px;
    endfunction

    function void note_request(input request_t r);
      longint unsigned addr;
      if (r.action == ACT_WRITE) begin
        addr = 64'(r.src_row) * 64'(width) + 64'(r.src_col);
        if (addr < STORE_DEPTH) begin
          frame[addr]   = r.src_value;
          written[addr] = 1'b1;
        end
      end else begin
        pixels_due.push_back(interpolate(r.dst_col, r.dst_row));
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    task report(input string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(input logic [RES_W-1:0] value, input logic in_img);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        report($sformatf("result %h/%b with no sample outstanding", value, in_img));
        return;
      end
      want = pixels_due.pop_front();
      if (value !== want.value)
        report($sformatf("dst (%0d,%0d) sample_value %h, want %h",
                         want.dst_col, want.dst_row, value, want.value));
      if (in_img !== want.in_img)
        report($sformatf("dst (%0d,%0d) inside_res %b, want %b",
                         want.dst_col, want.dst_row, in_img, want.in_img));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_left;
  int   requests_sent;
  pixel_scoreboard sb;

  bir_in_if  in_ch();
  bir_out_if out_ch();
  bir_cfg_if cfg_ch();

  bilinear_image_resampler_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch),
    .cfg_wr  (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick ready for the next edge.
  // A hold-off request from the run plan keeps ready low for a counted stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_pixel(out_ch.sample_value, out_ch.inside_res);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic pix_t pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Fill every field at random; the fields the action ignores stay as noise.
  function automatic request_t random_request(input logic action);
    request_t r;
    r.action    = action;
    r.src_col   = COORD_W'($urandom);
    r.src_row   = COORD_W'($urandom);
    r.src_value = pick_value();
    r.dst_col   = DST_W'($urandom);
    r.dst_row   = DST_W'($urandom);
    return r;
  endfunction

  // Pick one destination index, mostly one that maps inside the source.
  function automatic logic [DST_W-1:0] pick_axis(input longint unsigned org,
                                                 input longint unsigned dim);
    longint unsigned span;
    if (org >= dim || $urandom_range(99) < 20) return DST_W'($urandom_range(OUT_DIM - 1));
    span = (((dim - org) << FRAC_W) + 64'(sb.scale) - 1) / 64'(sb.scale);
    if (span > OUT_DIM) span = OUT_DIM;
    return DST_W'($urandom_range(32'(span) - 1));
  endfunction

  // Offer one request, with random idle cycles ahead of it; note it once accepted.
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= r.action;
    in_ch.src_col   <= r.src_col;
    in_ch.src_row   <= r.src_row;
    in_ch.src_value <= r.src_value;
    in_ch.dst_col   <= r.dst_col;
    in_ch.dst_row   <= r.dst_row;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic write_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                             input pix_t value);
    request_t r;
    r = random_request(ACT_WRITE);
    r.src_col   = col;
    r.src_row   = row;
    r.src_value = value;
    send_request(r);
  endtask

  // Sample one output pixel. Load every store entry that the sample reads and that
  // was never written; drop the sample if such an entry cannot be addressed with
  // the current width.
  task automatic sample_at(input logic [DST_W-1:0] dcol, input logic [DST_W-1:0] drow);
    longint unsigned reads[$];
    longint unsigned a, row;
    request_t fill[$];
    request_t r;
    void'(sb.interpolate(dcol, drow));
    reads = sb.last_reads;
    foreach (reads[i]) begin
      a = reads[i];
      if (sb.written[a]) continue;
      row = a / 64'(sb.width);
      if (row > COORD_MAX) row = COORD_MAX;
      if (a - row * 64'(sb.width) > COORD_MAX) return;
      r = random_request(ACT_WRITE);
      r.src_row = COORD_W'(row);
      r.src_col = COORD_W'(a - row * 64'(sb.width));
      fill.push_back(r);
    end
    foreach (fill[i]) send_request(fill[i]);
    r = random_request(ACT_SAMPLE);
    r.dst_col = dcol;
    r.dst_row = drow;
    send_request(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  // Reprogram all registers once the block is idle. Writes leave no result, so
  // let the pipeline run empty after the last result before touching the registers.
  task automatic apply_setting(input setting_t s);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_UNMAPPED,   CFG_DATA_W'($urandom));
    write_reg(REG_SRC_WIDTH,  CFG_DATA_W'(s.w));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(s.h));
    write_reg(REG_ORIGIN_X,   CFG_DATA_W'(s.ox));
    write_reg(REG_ORIGIN_Y,   CFG_DATA_W'(s.oy));
    write_reg(REG_SCALE_STEP, CFG_DATA_W'(s.scale));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    setting_t plan [N_PHASES];
    setting_t s;
    int phase_base;
    bit held;
    bit drained;

    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_WRITE;
    in_ch.src_col   <= '0;
    in_ch.src_row   <= '0;
    in_ch.src_value <= '0;
    in_ch.dst_col   <= '0;
    in_ch.dst_row   <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_SRC_WIDTH;
    cfg_ch.data     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: unit scale, so only base pixels are read.
    write_pixel(8'd0, 8'd0, '1);
    write_pixel(8'd255, 8'd255, '1);
    write_pixel(8'd128, 8'd7, '0);
    sample_at(9'd0, 9'd0);
    sample_at(9'd255, 9'd255);     // last entry of the store
    sample_at(9'd128, 9'd7);
    sample_at(9'd256, 9'd0);       // past the right edge
    sample_at(9'd0, 9'd511);       // past the bottom edge
    sample_at(9'd511, 9'd511);

    // Half steps from the last column: the right neighbor wraps to the next row, and in
    // the last row the right, lower and diagonal neighbors fall past the end of the store.
    s = '{9'd256, 9'd256, 8'd255, 8'd0, 24'h008000};
    apply_setting(s);
    sample_at(9'd1, 9'd0);
    sample_at(9'd1, 9'd511);
    sample_at(9'd3, 9'd0);
    sample_at(9'd0, 9'd0);

    // Tiny step: a fraction of exactly the threshold drops its neighbor, one above keeps it.
    s = '{9'd3, 9'd2, 8'd0, 8'd0, 24'd65};
    apply_setting(s);
    sample_at(9'd1, 9'd1);
    sample_at(9'd2, 9'd2);
    sample_at(9'd511, 9'd1);

    plan[0] = '{SRC_WIDTH_RST, SRC_HEIGHT_RST, 8'd0, 8'd0, SCALE_STEP_RST};
    plan[1] = '{9'd1, 9'd1, 8'd0, 8'd0, 24'd1};
    plan[2] = '{9'd256, 9'd256, 8'd255, 8'd255, 24'hFFFFFF};
    plan[3] = '{9'd7, 9'd5, 8'd2, 8'd1, 24'h006000};
    plan[4] = '{9'd200, 9'd150, 8'd10, 8'd20, 24'h014CCD};
    plan[5] = '{9'd256, 9'd1, 8'd128, 8'd0, 24'h0000C0};
    plan[6] = '{DIM_W'($urandom_range(256, 1)), DIM_W'($urandom_range(256, 1)),
                COORD_W'($urandom), COORD_W'($urandom), SCALE_W'($urandom_range(24'h3FFFF, 1))};
    plan[7] = '{DIM_W'($urandom_range(256, 1)), DIM_W'($urandom_range(256, 1)),
                COORD_W'($urandom), COORD_W'($urandom), SCALE_W'($urandom_range(24'hFFFFFF, 1))};

    for (int p = 0; p < N_PHASES; p++) begin
      apply_setting(plan[p]);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 59; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      phase_base = requests_sent;
      held       = 1'b0;
      drained    = 1'b0;
      while (requests_sent - phase_base < PHASE_REQUESTS) begin
        // Hold off results while requests keep coming, so the pipeline backs up.
        if (send_idle_pct == 0 && !held && requests_sent - phase_base >= PHASE_REQUESTS / 3) begin
          hold_left = HOLD_OFF_CYCLES;
          held      = 1'b1;
        end
        // Pause requests until every outstanding result is back.
        if (!drained && requests_sent - phase_base >= 2 * PHASE_REQUESTS / 3) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
          drained = 1'b1;
        end
        if ($urandom_range(99) < 25)
          send_request(random_request(ACT_WRITE));
        else
          sample_at(pick_axis(sb.org_x, sb.width), pick_axis(sb.org_y, sb.height));
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/bir_pkg.sv
hdl/bir_if.sv
hdl/bilinear_image_resampler_unit.sv
tb/sv/tb.sv
